@@ rtl/core/rakth_pkg.sv @@
// Shared types, constants and helpers for the range add / k-th smallest block.
// No dependencies.
package rakth_pkg;

    localparam int DEPTH       = 1024;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SRCH_W      = VALUE_WIDTH + 2;

    localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_QSETUP,
        S_QSCAN,
        S_QDECIDE,
        S_RESULT
    } t_state;

    // Saturating signed add of two values.
    function automatic logic signed [VALUE_WIDTH-1:0] sat_add(
        input logic signed [VALUE_WIDTH-1:0] a,
        input logic signed [VALUE_WIDTH-1:0] b
    );
        logic signed [VALUE_WIDTH:0] s;
        s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
        if (s > $signed({VMAX[VALUE_WIDTH-1], VMAX})) begin
            return VMAX;
        end else if (s < $signed({VMIN[VALUE_WIDTH-1], VMIN})) begin
            return VMIN;
        end
        return s[VALUE_WIDTH-1:0];
    endfunction

endpackage

@@ rtl/core/rakth_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies.
module rakth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ rtl/core/range_add_kth_smallest.sv @@
// Top level of the range add / k-th smallest block.
// Depends on rakth_pkg and rakth_ram.
//
// The element array lives in one dual-port RAM that is read one element per
// cycle. A load is written in the cycle it is accepted. A range add streams
// a read-modify-write over its range. A query runs a binary search between
// the tracked low and high bounds; each probe scans the range through the RAM
// read port, and a query makes at most 33 probes. An invalid query goes
// straight to the result state. Items are taken one at a time; a result waits
// in the output register while the next item is accepted.
module range_add_kth_smallest
    import rakth_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: element_count.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data,
    // tdata: left_index[9:0], right_index[19:10], operand_value[51:20], zero pad.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    // tuser: opcode[1:0].
    input  logic [1:0]  s_axis_tuser,
    // tdata: kth_value[31:0].
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,
    // tuser: out_of_range[0].
    output logic        m_axis_tuser
);

    t_state r_state, n_state;

    logic [10:0]                   r_count;
    logic signed [VALUE_WIDTH-1:0] r_low, r_high;
    logic [ADDR_W-1:0]             r_end;
    logic [CNT_W-1:0]              r_ptr;
    logic                          r_issue, r_pend;
    logic [ADDR_W-1:0]             r_pend_addr;
    logic signed [VALUE_WIDTH-1:0] r_operand;
    logic [ADDR_W-1:0]             r_left;
    logic signed [SRCH_W-1:0]      r_lo, r_hi, r_mid;
    logic signed [VALUE_WIDTH-1:0] r_res;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_ovf;
    logic                          r_out_valid;
    logic [VALUE_WIDTH-1:0]        r_out_data;
    logic                          r_out_flag;

    logic [1:0]                    in_op;
    logic [ADDR_W-1:0]             in_left, in_right;
    logic signed [VALUE_WIDTH-1:0] in_val;
    logic                          in_acc;
    logic [CNT_W-1:0]              used_n;
    logic                          range_ok, k_ok;
    logic [CNT_W-1:0]              range_len;

    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr, ram_raddr;
    logic [VALUE_WIDTH-1:0]        ram_wdata, ram_rdata;
    logic signed [VALUE_WIDTH-1:0] load_val;
    logic signed [SRCH_W-1:0]      new_mid;

    assign in_op    = s_axis_tuser;
    assign in_left  = s_axis_tdata[9:0];
    assign in_right = s_axis_tdata[19:10];
    assign in_val   = s_axis_tdata[51:20];
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    assign used_n    = (r_count > 11'(DEPTH)) ? CNT_W'(DEPTH) : r_count[CNT_W-1:0];
    assign range_ok  = (in_left <= in_right) && ({1'b0, in_right} < used_n);
    assign range_len = {1'b0, in_right} - {1'b0, in_left} + CNT_W'(1);
    assign k_ok      = (in_val >= 32'sd1) &&
                       ({{(VALUE_WIDTH-CNT_W){1'b0}}, range_len} >= in_val);
    assign load_val  = in_val;
    assign new_mid   = r_lo + ((r_hi - r_lo) >>> 1);

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_flag;

    rakth_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH), .AW(ADDR_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_op == OP_ADD && range_ok) begin
                        n_state = S_ADD;
                    end else if (in_op == OP_QUERY) begin
                        n_state = (range_ok && k_ok) ? S_QSETUP : S_RESULT;
                    end
                end
            end
            S_ADD: begin
                if (!r_issue && !r_pend) n_state = S_IDLE;
            end
            S_QSETUP: begin
                n_state = (r_lo <= r_hi) ? S_QSCAN : S_RESULT;
            end
            S_QSCAN: begin
                if (!r_issue && !r_pend) n_state = S_QDECIDE;
            end
            S_QDECIDE: n_state = S_QSETUP;
            S_RESULT: begin
                if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and memory control.
    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = r_pend_addr;
        ram_wdata     = sat_add(ram_rdata, r_operand);
        ram_raddr     = r_ptr[ADDR_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_acc && in_op == OP_LOAD && {1'b0, in_left} < used_n) begin
                    ram_we    = 1'b1;
                    ram_waddr = in_left;
                    ram_wdata = load_val;
                end
            end
            S_ADD:   ram_we = r_pend;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= 11'd1024;
            r_low       <= VMAX;
            r_high      <= VMIN;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_count <= i_cfg_data;
            if (r_out_valid && m_axis_tready && r_state != S_RESULT) r_out_valid <= 1'b0;

            // Streaming scan shared by the range add and the query probes.
            r_pend      <= r_issue;
            r_pend_addr <= r_ptr[ADDR_W-1:0];
            if (r_issue) begin
                if (r_ptr[ADDR_W-1:0] == r_end) r_issue <= 1'b0;
                r_ptr <= r_ptr + CNT_W'(1);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_left    <= in_left;
                        r_end     <= in_right;
                        r_operand <= in_val;
                        r_ovf     <= !(range_ok && k_ok);
                        r_res     <= r_high;
                        r_lo      <= SRCH_W'(r_low);
                        r_hi      <= SRCH_W'(r_high);
                        if (in_op == OP_LOAD && {1'b0, in_left} < used_n) begin
                            if (load_val < r_low)  r_low  <= load_val;
                            if (load_val > r_high) r_high <= load_val;
                        end
                        if (in_op == OP_ADD && range_ok) begin
                            r_ptr   <= {1'b0, in_left};
                            r_issue <= 1'b1;
                            if (in_val > 0) begin
                                r_high <= sat_add(r_high, in_val);
                            end else if (in_val < 0) begin
                                r_low <= sat_add(r_low, in_val);
                            end
                        end
                    end
                end
                S_QSETUP: begin
                    if (r_lo <= r_hi) begin
                        r_mid   <= new_mid;
                        r_ptr   <= {1'b0, r_left};
                        r_issue <= 1'b1;
                        r_cnt   <= '0;
                    end
                end
                S_QSCAN: begin
                    if (r_pend && SRCH_W'($signed(ram_rdata)) <= r_mid) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_QDECIDE: begin
                    if ({{(VALUE_WIDTH-CNT_W){1'b0}}, r_cnt} >= r_operand) begin
                        r_res <= r_mid[VALUE_WIDTH-1:0];
                        r_hi  <= r_mid - SRCH_W'(1);
                    end else begin
                        r_lo  <= r_mid + SRCH_W'(1);
                    end
                end
                S_RESULT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_ovf ? '0 : r_res;
                        r_out_flag  <= r_ovf;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
